FILE: src/ssar_pkg.sv
// ----------------------------------------------------------------------------
// ssar_pkg: shared types and constants for the stick scroll auto-repeat unit
// Field widths, register indexes, reset values and the sample class type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssar_pkg;

	localparam int SampleW    = 12;
	localparam int ThreshW    = 11;
	localparam int IntervalW  = 8;
	localparam int UnitW      = 8;
	localparam int AmountW    = 11;
	localparam int CountW     = 9;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 11;
	localparam int InTdataW   = 16;
	localparam int OutTdataW  = 16;

	localparam logic [ThreshW-1:0]   SlowThreshRst = ThreshW'(200);
	localparam logic [ThreshW-1:0]   FastThreshRst = ThreshW'(900);
	localparam logic [IntervalW-1:0] IntervalRst   = IntervalW'(6);
	localparam logic [UnitW-1:0]     UnitRst       = UnitW'(70);

	typedef enum logic [CfgIndexW-1:0] {
		CFG_SLOW_THRESHOLD  = 2'd0,
		CFG_FAST_THRESHOLD  = 2'd1,
		CFG_REPEAT_INTERVAL = 2'd2,
		CFG_WHEEL_UNIT      = 2'd3
	} cfg_idx_t;

	// neg and pos never both set; fast qualifies whichever is set
	typedef struct packed {
		logic neg;
		logic pos;
		logic fast;
	} stick_class_t;

endpackage

`default_nettype wire

FILE: src/ssar_classify.sv
// ----------------------------------------------------------------------------
// ssar_classify: stick sample classifier
// Sorts a signed sample into none, slow or fast in either direction.
// ----------------------------------------------------------------------------
`default_nettype none

module ssar_classify (
	input  wire logic signed [ssar_pkg::SampleW-1:0] sample,
	input  wire logic [ssar_pkg::ThreshW-1:0]        slow_threshold,
	input  wire logic [ssar_pkg::ThreshW-1:0]        fast_threshold,
	output ssar_pkg::stick_class_t                   cls
);

	logic signed [ssar_pkg::SampleW:0] s_x;
	logic signed [ssar_pkg::SampleW:0] slow_x;
	logic signed [ssar_pkg::SampleW:0] fast_x;
	logic neg_slow, neg_fast, pos_slow, pos_fast;

	always_comb begin
		s_x    = {sample[ssar_pkg::SampleW-1], sample};
		slow_x = $signed({2'b00, slow_threshold});
		fast_x = $signed({2'b00, fast_threshold});
		neg_slow = s_x < -slow_x;
		neg_fast = s_x < -fast_x;
		pos_slow = s_x > slow_x;
		pos_fast = s_x > fast_x;
		// a fast match wins even when the fast threshold sits below the slow one
		cls.neg  = neg_slow | neg_fast;
		cls.pos  = pos_slow | pos_fast;
		cls.fast = pos_slow | pos_fast ? pos_fast : neg_fast;
	end

endmodule

`default_nettype wire

FILE: src/ssar_repeat.sv
// ----------------------------------------------------------------------------
// ssar_repeat: per-direction hold and repeat countdown
// Keeps held flags and countdowns and decides whether a step emits an event.
// ----------------------------------------------------------------------------
`default_nettype none

module ssar_repeat (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               step,
	input  wire ssar_pkg::stick_class_t             cls,
	input  wire logic [ssar_pkg::IntervalW-1:0]     repeat_interval,
	output logic                                    fire
);

	logic                          neg_held_q, pos_held_q;
	logic [ssar_pkg::CountW-1:0]   neg_cd_q, pos_cd_q;
	logic                          neg_held_d, pos_held_d;
	logic [ssar_pkg::CountW-1:0]   neg_cd_d, pos_cd_d;
	logic [ssar_pkg::CountW-1:0]   reload;

	assign reload = {1'b0, repeat_interval};

	always_comb begin
		neg_held_d = neg_held_q;
		pos_held_d = pos_held_q;
		neg_cd_d   = neg_cd_q;
		pos_cd_d   = pos_cd_q;
		fire       = 1'b0;

		if (cls.neg) begin
			if (!neg_held_q) begin
				fire       = 1'b1;
				neg_held_d = 1'b1;
				// a fast first tick leaves the countdown alone
				if (!cls.fast) begin
					neg_cd_d = reload;
				end
			end else if (neg_cd_q <= ssar_pkg::CountW'(1)) begin
				fire     = 1'b1;
				neg_cd_d = reload;
			end else begin
				neg_cd_d = neg_cd_q - ssar_pkg::CountW'(1);
			end
		end else begin
			neg_held_d = 1'b0;
		end

		if (cls.pos) begin
			if (!pos_held_q) begin
				// a fast first tick arms the hold without emitting
				fire       = !cls.fast;
				pos_held_d = 1'b1;
				pos_cd_d   = reload;
			end else if (pos_cd_q <= ssar_pkg::CountW'(1)) begin
				fire     = 1'b1;
				pos_cd_d = reload;
			end else begin
				pos_cd_d = pos_cd_q - ssar_pkg::CountW'(1);
			end
		end else begin
			pos_held_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_held_q <= 1'b0;
			pos_held_q <= 1'b0;
			neg_cd_q   <= '0;
			pos_cd_q   <= '0;
		end else if (step) begin
			neg_held_q <= neg_held_d;
			pos_held_q <= pos_held_d;
			neg_cd_q   <= neg_cd_d;
			pos_cd_q   <= pos_cd_d;
		end
	end

	a_held_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(neg_held_q && pos_held_q))
		else $error("both directions held");

	a_fire_needs_class: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (cls.neg || cls.pos))
		else $error("event with centered stick");

	a_neg_hold_set: assert property (@(posedge clk) disable iff (!arst_n)
		(step && cls.neg) |=> neg_held_q)
		else $error("negative hold not recorded");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !cls.neg && !cls.pos) |=> (!neg_held_q && !pos_held_q))
		else $error("hold survived release");

endmodule

`default_nettype wire

FILE: src/stick_scroll_auto_repeat_unit.sv
// ----------------------------------------------------------------------------
// stick_scroll_auto_repeat_unit: joystick to wheel auto-repeat
// Turns held vertical stick deflection into repeated wheel events.
// ----------------------------------------------------------------------------
// Takes one stick sample per clock cycle while not stalled: the sample is
// registered, then classified and run against the hold state, and a wheel
// event, if any, lands in the output register. Samples that cause no
// event produce no output item. The output register drains while the next
// sample is taken, so the input stalls only while a waiting event is not
// taken. Configuration registers reset to slow 200, fast 900, interval 6,
// unit 70 and may be written only while no sample is in flight.
`default_nettype none

module stick_scroll_auto_repeat_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [ssar_pkg::InTdataW-1:0]     s_axis_tdata,  // [11:0] stick_sample
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [ssar_pkg::OutTdataW-1:0]         m_axis_tdata,  // [10:0] wheel_amount
	input  wire logic                              cfg_we,
	input  wire logic [ssar_pkg::CfgIndexW-1:0]    cfg_index,
	input  wire logic [ssar_pkg::CfgDataW-1:0]     cfg_wdata
);

	logic [ssar_pkg::ThreshW-1:0]   slow_threshold_q;
	logic [ssar_pkg::ThreshW-1:0]   fast_threshold_q;
	logic [ssar_pkg::IntervalW-1:0] repeat_interval_q;
	logic [ssar_pkg::UnitW-1:0]     wheel_unit_q;

	logic                                 valid_s1;
	logic signed [ssar_pkg::SampleW-1:0]  sample_s1;
	logic                                 valid_s2;
	logic [ssar_pkg::AmountW-1:0]         wheel_amount_s2;

	logic                          advance;
	logic                          step;
	logic                          fire;
	ssar_pkg::stick_class_t        cls;
	logic [ssar_pkg::UnitW+1:0]    mag;
	logic [ssar_pkg::AmountW-1:0]  amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_threshold_q  <= ssar_pkg::SlowThreshRst;
			fast_threshold_q  <= ssar_pkg::FastThreshRst;
			repeat_interval_q <= ssar_pkg::IntervalRst;
			wheel_unit_q      <= ssar_pkg::UnitRst;
		end else if (cfg_we) begin
			unique case (ssar_pkg::cfg_idx_t'(cfg_index))
				ssar_pkg::CFG_SLOW_THRESHOLD: begin
					slow_threshold_q <= cfg_wdata[ssar_pkg::ThreshW-1:0];
				end
				ssar_pkg::CFG_FAST_THRESHOLD: begin
					fast_threshold_q <= cfg_wdata[ssar_pkg::ThreshW-1:0];
				end
				ssar_pkg::CFG_REPEAT_INTERVAL: begin
					repeat_interval_q <= cfg_wdata[ssar_pkg::IntervalW-1:0];
				end
				ssar_pkg::CFG_WHEEL_UNIT: begin
					wheel_unit_q <= cfg_wdata[ssar_pkg::UnitW-1:0];
				end
			endcase
		end
	end

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	ssar_classify u_classify (
		.sample         (sample_s1),
		.slow_threshold (slow_threshold_q),
		.fast_threshold (fast_threshold_q),
		.cls            (cls)
	);

	ssar_repeat u_repeat (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.cls             (cls),
		.repeat_interval (repeat_interval_q),
		.fire            (fire)
	);

	always_comb begin
		if (cls.fast) begin
			mag = {2'b00, wheel_unit_q} + {1'b0, wheel_unit_q, 1'b0};
		end else begin
			mag = {2'b00, wheel_unit_q};
		end
		if (cls.neg) begin
			amount = -{1'b0, mag};
		end else begin
			amount = {1'b0, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= step && fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= $signed(s_axis_tdata[ssar_pkg::SampleW-1:0]);
		end
		if (step && fire) begin
			wheel_amount_s2 <= amount;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(ssar_pkg::OutTdataW-ssar_pkg::AmountW){1'b0}}, wheel_amount_s2};

endmodule

`default_nettype wire

FILE: tb/sv/tb_stick_scroll_auto_repeat_unit.sv
// ----------------------------------------------------------------------------
// tb_stick_scroll_auto_repeat_unit: self-checking bench for the scroll unit
// Streams stick samples, predicts wheel events from an internal model of the
// hold flags and repeat countdowns, and checks every output item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stick_scroll_auto_repeat_unit;

	import ssar_pkg::*;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [AmountW-1:0]        amount_t;

	localparam int CycleLimit  = 400000;
	localparam int DrainCycles = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InTdataW-1:0]  s_axis_tdata = '0;   // [11:0] stick_sample
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutTdataW-1:0] m_axis_tdata;        // [10:0] wheel_amount
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = CFG_SLOW_THRESHOLD;
	logic [CfgDataW-1:0]  cfg_wdata = '0;

	stick_scroll_auto_repeat_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model copy of configuration and hold state
	logic [ThreshW-1:0]   slow_thr = SlowThreshRst;
	logic [ThreshW-1:0]   fast_thr = FastThreshRst;
	logic [IntervalW-1:0] repeat_ival = IntervalRst;
	logic [UnitW-1:0]     wheel_u = UnitRst;
	bit neg_held = 1'b0;
	bit pos_held = 1'b0;
	int neg_cd = 0;
	int pos_cd = 0;

	amount_t expected_wheel_q[$];
	int fail_count = 0;
	int sent_items = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;

	function automatic bit step_countdown(inout int cd);
		int nxt;
		nxt = cd - 1;
		if (nxt <= 0) begin
			cd = int'(repeat_ival);
			return 1'b1;
		end
		cd = nxt & 'h1FF;
		return 1'b0;
	endfunction

	function automatic void predict_wheel_event(sample_t s);
		int sv;
		int cls;
		int mag;
		bit fire;
		sv = s;
		cls = 0;
		fire = 1'b0;
		// later tests override earlier ones
		if (sv < -int'(slow_thr)) cls = -1;
		if (sv < -int'(fast_thr)) cls = -2;
		if (sv > int'(slow_thr)) cls = 1;
		if (sv > int'(fast_thr)) cls = 2;
		if (cls < 0) begin
			if (!neg_held) begin
				fire = 1'b1;
				neg_held = 1'b1;
				// fast first tick keeps the stale countdown
				if (cls == -1) neg_cd = int'(repeat_ival);
			end else begin
				fire = step_countdown(neg_cd);
			end
		end else begin
			neg_held = 1'b0;
		end
		if (cls > 0) begin
			if (!pos_held) begin
				if (cls == 1) fire = 1'b1;
				pos_held = 1'b1;
				pos_cd = int'(repeat_ival);
			end else begin
				fire = step_countdown(pos_cd);
			end
		end else begin
			pos_held = 1'b0;
		end
		if (fire) begin
			mag = int'(wheel_u) * ((cls == 2 || cls == -2) ? 3 : 1);
			if (cls < 0) mag = -mag;
			expected_wheel_q.push_back(amount_t'(mag));
		end
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random ready, or a long hold-off on request
	always @(posedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		amount_t got;
		amount_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[AmountW-1:0];
			if (expected_wheel_q.size() == 0) begin
				$error("wheel_amount: expected none, got %0d", $signed(got));
				fail_count++;
			end else begin
				want = expected_wheel_q.pop_front();
				if (got !== want) begin
					$error("wheel_amount: expected %0d, got %0d", $signed(want), $signed(got));
					fail_count++;
				end
			end
		end
	end

	task automatic send_sample(sample_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= InTdataW'({1'b0, s}) & InTdataW'({SampleW{1'b1}});
		do @(posedge clk); while (!s_axis_tready);
		predict_wheel_event(s);
		sent_items++;
	endtask

	// wait until all events are out and nothing is left in the pipe
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_wheel_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_SLOW_THRESHOLD:  slow_thr = val[ThreshW-1:0];
			CFG_FAST_THRESHOLD:  fast_thr = val[ThreshW-1:0];
			CFG_REPEAT_INTERVAL: repeat_ival = val[IntervalW-1:0];
			CFG_WHEEL_UNIT:      wheel_u = val[UnitW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int slow, int fast, int ival, int unit);
		wait_idle();
		write_reg(CFG_SLOW_THRESHOLD, CfgDataW'(slow));
		write_reg(CFG_FAST_THRESHOLD, CfgDataW'(fast));
		write_reg(CFG_REPEAT_INTERVAL, CfgDataW'(ival));
		write_reg(CFG_WHEEL_UNIT, CfgDataW'(unit));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_noise();
		send_sample(sample_t'($urandom_range(0, 4095)));
	endtask

	// one hold, mostly near a threshold, with jitter, then an optional release
	task automatic send_hold();
		int base;
		int sgn;
		int len;
		int mag;
		int lim;
		int k;
		if ($urandom_range(3) == 0)
			base = $urandom_range(0, 2047);
		else
			base = ($urandom_range(1) ? int'(slow_thr) : int'(fast_thr))
				+ $urandom_range(1, 48) - 8;
		sgn = $urandom_range(1) ? 1 : -1;
		lim = (sgn < 0) ? 2048 : 2047;
		len = $urandom_range(1, 2 * int'(repeat_ival) + 4);
		if (len > 300) len = 300;
		for (int j = 0; j < len; j++) begin
			mag = base + $urandom_range(0, 8) - 4;
			if (mag < 0) mag = 0;
			if (mag > lim) mag = lim;
			send_sample(sample_t'(sgn * mag));
		end
		k = $urandom_range(0, 3);
		for (int j = 0; j < k; j++)
			send_sample(sample_t'(int'($urandom_range(0, 2 * int'(slow_thr))) - int'(slow_thr)));
	endtask

	task automatic run_random(int n);
		int start;
		start = sent_items;
		while (sent_items - start < n) begin
			if ($urandom_range(99) < 20)
				send_noise();
			else
				send_hold();
		end
	endtask

	task automatic randomize_config();
		int slow;
		int fast;
		slow = $urandom_range(0, 1200);
		if ($urandom_range(4) == 0)
			fast = $urandom_range(0, 2047);
		else
			fast = slow + $urandom_range(1, 800);
		set_config(slow, fast, $urandom_range(1, 12), $urandom_range(1, 255));
	endtask

	// reset values: edges of both thresholds, repeats, fast first ticks
	task automatic test_reset_defaults();
		sample_t pattern [25] = '{
			0, 200, 201, 2047, 0, 901, 900, -200, -201, -2048, -901, -900,
			-1000, -1000, -1000, 0, -2048, -2048, -2048, 0, 1, -1,
			2047, 2047, 2047
		};
		foreach (pattern[i]) send_sample(pattern[i]);
	endtask

	// fast threshold below slow: the band between counts as fast
	task automatic test_fast_below_slow();
		sample_t pattern [8] = '{300, 800, 800, 0, -300, -800, 100, -100};
		set_config(700, 250, 3, 10);
		foreach (pattern[i]) send_sample(pattern[i]);
		run_random(100);
	endtask

	// interval zero fires every held tick; unit zero emits zero amounts
	task automatic test_zero_interval_and_unit();
		set_config(200, 900, 0, 0);
		run_random(80);
		set_config(150, 1500, 0, 255);
		run_random(60);
	endtask

	task automatic test_random_configs(int phases, int n);
		for (int p = 0; p < phases; p++) begin
			randomize_config();
			run_random(n);
		end
	endtask

	// the long-interval phases ask for fewer samples than the others
	task automatic test_register_extremes();
		set_config(0, 0, 1, 1);
		run_random(80);
		set_config(2047, 2047, 255, 255);
		run_random(20);
		set_config(0, 2047, 255, 1);
		run_random(20);
		set_config(2047, 0, 1, 255);
		run_random(60);
	endtask

	// long receiver hold-off fills the pipe, then a full drain before more
	task automatic test_backpressure();
		set_config(300, 1000, 1, $urandom_range(1, 255));
		rx_hold_req = 300;
		run_random(120);
		wait_idle();
		run_random(60);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 31;
		rx_idle_pct = 46;
		test_reset_defaults();
		test_fast_below_slow();
		test_zero_interval_and_unit();
		test_random_configs(2, 100);

		tx_idle_pct = 46;
		rx_idle_pct = 31;
		test_random_configs(2, 100);
		test_register_extremes();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_configs(3, 100);
		test_backpressure();

		wait_idle();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
